// File: rtl/assert_macros.svh
// Assertion macros used by the parser core RTL.
// Each macro expects clk_i and rst_ni to be visible at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/btlv_pkg.sv
// ----------------------------------------------------------------------------
// btlv_pkg
// Types and constants for the BER tag-length-value stream parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package btlv_pkg;

  localparam int OFFSET_WIDTH     = 16;
  localparam int MAX_LENGTH_BYTES = 4;
  localparam int LEN_BIG_BYTES    = 4;
  localparam int TAG_MAX_BYTES    = 4;
  localparam int FIFO_DEPTH       = 4;
  localparam int FIFO_PTR_W       = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W       = $clog2(FIFO_DEPTH + 1);

  localparam logic [OFFSET_WIDTH-1:0] OFFSET_LIMIT = {OFFSET_WIDTH{1'b1}};
  localparam logic [15:0] MAX_TOKENS_RESET = 16'hFFFF;
  localparam logic [4:0]  TAG_EXT_MARK     = 5'h1F;

  typedef enum logic [2:0] {
    PH_TAG_FIRST,
    PH_TAG_EXT,
    PH_LEN_FIRST,
    PH_LEN_LONG,
    PH_VALUE
  } btlv_phase_e;

  typedef enum logic [1:0] {
    KIND_TOKEN = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } btlv_kind_e;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_TOKENS   = 3'd1,
    ERR_INVALID  = 3'd2,
    ERR_OVERFLOW = 3'd3,
    ERR_TRUNC    = 3'd4
  } btlv_err_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } btlv_in_t;

  typedef struct packed {
    logic [1:0]              result_kind;
    logic [31:0]             tag_value;
    logic [30:0]             length_value;
    logic [OFFSET_WIDTH-1:0] value_offset;
    logic [15:0]             token_index;
    logic [2:0]              error_code;
    logic [OFFSET_WIDTH-1:0] total_length;
    logic                    last_result;
  } btlv_out_t;

  // Byte as classified by the front end.
  typedef struct packed {
    logic [7:0] byte_val;
    logic       fin;
    logic       ext_tag;
    logic       is_zero;
    logic       is_ff;
    logic       cnt_big;
    logic       cnt_zero;
  } btlv_cls_t;

  typedef struct packed {
    btlv_phase_e             phase;
    logic [31:0]             tag_accum;
    logic [2:0]              tag_cnt;
    logic [30:0]             len_accum;
    logic [2:0]              len_left;
    logic [30:0]             val_left;
    logic [OFFSET_WIDTH-1:0] offset;
    logic [15:0]             tok_cnt;
    logic                    err_latched;
  } btlv_state_t;

  localparam btlv_state_t STATE_CLEAR = '{
    phase:       PH_TAG_FIRST,
    tag_accum:   32'd0,
    tag_cnt:     3'd0,
    len_accum:   31'd0,
    len_left:    3'd0,
    val_left:    31'd0,
    offset:      {OFFSET_WIDTH{1'b0}},
    tok_cnt:     16'd0,
    err_latched: 1'b0
  };

endpackage

`default_nettype wire

// File: rtl/btlv_front.sv
// ----------------------------------------------------------------------------
// btlv_front
// Input stage: takes byte requests and tags each with its decode flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module btlv_front (
  input  var btlv_pkg::btlv_in_t  in_data_i,
  output btlv_pkg::btlv_cls_t     cls_o
);

  always_comb begin
    cls_o.byte_val = in_data_i.data_byte;
    cls_o.fin      = in_data_i.final_byte;
    cls_o.ext_tag  = (in_data_i.data_byte[4:0] == btlv_pkg::TAG_EXT_MARK);
    cls_o.is_zero  = (in_data_i.data_byte == 8'h00);
    cls_o.is_ff    = (in_data_i.data_byte == 8'hFF);
    cls_o.cnt_big  = (in_data_i.data_byte[6:0] > 7'(btlv_pkg::MAX_LENGTH_BYTES));
    cls_o.cnt_zero = (in_data_i.data_byte[6:0] == 7'd0);
  end

endmodule

`default_nettype wire

// File: rtl/btlv_fifo.sv
// ----------------------------------------------------------------------------
// btlv_fifo
// Short queue of classified bytes between front end and parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module btlv_fifo (
  input  var logic                clk_i,
  input  var logic                rst_ni,
  input  var logic                push_i,
  input  var btlv_pkg::btlv_cls_t push_data_i,
  output logic                    full_o,
  output logic                    not_empty_o,
  input  var logic                pop_i,
  output btlv_pkg::btlv_cls_t     pop_data_o
);

  btlv_pkg::btlv_cls_t mem_q [btlv_pkg::FIFO_DEPTH];

  logic [btlv_pkg::FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [btlv_pkg::FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [btlv_pkg::FIFO_CNT_W-1:0] count_q, count_d;

  localparam logic [btlv_pkg::FIFO_PTR_W-1:0] PTR_LAST =
    btlv_pkg::FIFO_PTR_W'(btlv_pkg::FIFO_DEPTH - 1);

  assign full_o      = (count_q == btlv_pkg::FIFO_CNT_W'(btlv_pkg::FIFO_DEPTH));
  assign not_empty_o = (count_q != '0);
  assign pop_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/btlv_back.sv
// ----------------------------------------------------------------------------
// btlv_back
// Parser core: runs the TLV header FSM on one queued byte per cycle unless
// held up, and drives results through an output register and a second slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module btlv_back (
  input  var logic                clk_i,
  input  var logic                rst_ni,
  input  var logic                q_avail_i,
  input  var btlv_pkg::btlv_cls_t q_data_i,
  output logic                    q_pop_o,
  input  var logic                cfg_valid_i,
  input  var logic [15:0]         cfg_data_i,
  output logic                    out_valid_o,
  input  var logic                out_stall_i,
  output btlv_pkg::btlv_out_t     out_data_o
);

  btlv_pkg::btlv_state_t state_q, state_d, s;
  logic [15:0]           max_tokens_q;

  logic                  emit;
  logic                  done;
  btlv_pkg::btlv_err_e   err;
  logic [31:0]           tok_tag;
  logic [30:0]           tok_len;
  logic [btlv_pkg::OFFSET_WIDTH-1:0] tok_off;
  logic [15:0]           tok_idx;

  btlv_pkg::btlv_out_t   rec_tok, rec_tail, first_rec, second_rec;
  logic                  has_any, has_two;

  logic                  out_valid_q, out_valid_d;
  btlv_pkg::btlv_out_t   out_q, out_d;
  logic                  pend_valid_q, pend_valid_d;
  btlv_pkg::btlv_out_t   pend_q, pend_d;
  logic                  out_free;

  assign out_free = !out_valid_q || !out_stall_i;
  assign q_pop_o  = q_avail_i && !pend_valid_q && out_free;

  // Next parser state for the byte at the head of the queue.
  always_comb begin
    s       = state_q;
    emit    = 1'b0;
    done    = 1'b0;
    err     = btlv_pkg::ERR_NONE;
    tok_tag = '0;
    tok_len = '0;
    tok_off = '0;
    tok_idx = '0;
    if (state_q.err_latched) begin
      // drop bytes until the end of the buffer
      if (q_data_i.fin) begin
        s = btlv_pkg::STATE_CLEAR;
      end
    end else begin
      if (state_q.offset == btlv_pkg::OFFSET_LIMIT) begin
        err = btlv_pkg::ERR_TRUNC;
      end else begin
        s.offset = state_q.offset + 1'b1;
        case (state_q.phase)
          btlv_pkg::PH_TAG_FIRST: begin
            if (state_q.tok_cnt >= max_tokens_q) begin
              err = btlv_pkg::ERR_TOKENS;
            end else begin
              s.tag_accum = {24'd0, q_data_i.byte_val};
              s.tag_cnt   = 3'd1;
              s.len_accum = '0;
              s.phase     = q_data_i.ext_tag ? btlv_pkg::PH_TAG_EXT : btlv_pkg::PH_LEN_FIRST;
            end
          end
          btlv_pkg::PH_TAG_EXT: begin
            if (state_q.tag_cnt == 3'd1 && q_data_i.is_zero) begin
              err = btlv_pkg::ERR_INVALID;
            end else if (state_q.tag_cnt >= 3'(btlv_pkg::TAG_MAX_BYTES)) begin
              err = btlv_pkg::ERR_OVERFLOW;
            end else begin
              s.tag_accum = {state_q.tag_accum[23:0], q_data_i.byte_val};
              s.tag_cnt   = state_q.tag_cnt + 1'b1;
              if (!q_data_i.byte_val[7]) begin
                s.phase = btlv_pkg::PH_LEN_FIRST;
              end
            end
          end
          btlv_pkg::PH_LEN_FIRST: begin
            if (q_data_i.byte_val[7]) begin
              if (q_data_i.is_ff) begin
                err = btlv_pkg::ERR_INVALID;
              end else if (q_data_i.cnt_big) begin
                err = btlv_pkg::ERR_OVERFLOW;
              end else if (q_data_i.cnt_zero) begin
                s.len_accum = '0;
                emit        = 1'b1;
              end else begin
                s.len_accum = '0;
                s.len_left  = q_data_i.byte_val[2:0];
                s.phase     = btlv_pkg::PH_LEN_LONG;
              end
            end else begin
              s.len_accum = {24'd0, q_data_i.byte_val[6:0]};
              emit        = 1'b1;
            end
          end
          btlv_pkg::PH_LEN_LONG: begin
            // a set top bit in the first of four bytes means 2^31 or more
            if (state_q.len_left >= 3'(btlv_pkg::LEN_BIG_BYTES) && q_data_i.byte_val[7]) begin
              err = btlv_pkg::ERR_OVERFLOW;
            end else begin
              s.len_accum = {state_q.len_accum[22:0], q_data_i.byte_val};
              s.len_left  = state_q.len_left - 1'b1;
              if (s.len_left == 3'd0) begin
                emit = 1'b1;
              end
            end
          end
          default: begin
            // skip value bytes
            if (state_q.val_left != '0) begin
              s.val_left = state_q.val_left - 1'b1;
            end
            if (s.val_left == '0) begin
              s.phase = btlv_pkg::PH_TAG_FIRST;
            end
          end
        endcase
        if (emit) begin
          tok_tag   = s.tag_accum;
          tok_len   = s.len_accum;
          tok_off   = s.offset;
          tok_idx   = s.tok_cnt;
          s.tok_cnt = s.tok_cnt + 1'b1;
          if (s.len_accum == '0) begin
            s.phase = btlv_pkg::PH_TAG_FIRST;
          end else begin
            s.val_left = s.len_accum;
            s.phase    = btlv_pkg::PH_VALUE;
          end
        end
      end
      if (err == btlv_pkg::ERR_NONE && q_data_i.fin) begin
        if (s.phase == btlv_pkg::PH_TAG_FIRST) begin
          done = 1'b1;
        end else begin
          err = btlv_pkg::ERR_TRUNC;
        end
      end
      if (err != btlv_pkg::ERR_NONE) begin
        s.err_latched = 1'b1;
      end
      if (q_data_i.fin) begin
        s = btlv_pkg::STATE_CLEAR;
      end
    end
    state_d = q_pop_o ? s : state_q;
  end

  // Result records for the same byte.
  always_comb begin
    rec_tok              = '0;
    rec_tok.result_kind  = btlv_pkg::KIND_TOKEN;
    rec_tok.tag_value    = tok_tag;
    rec_tok.length_value = tok_len;
    rec_tok.value_offset = tok_off;
    rec_tok.token_index  = tok_idx;

    rec_tail = '0;
    if (done) begin
      rec_tail.result_kind  = btlv_pkg::KIND_DONE;
      rec_tail.total_length = state_q.offset + 1'b1;
    end else begin
      rec_tail.result_kind = btlv_pkg::KIND_ERROR;
      rec_tail.error_code  = err;
    end

    has_any = emit || done || (err != btlv_pkg::ERR_NONE);
    has_two = emit && (done || (err != btlv_pkg::ERR_NONE));

    first_rec              = emit ? rec_tok : rec_tail;
    first_rec.last_result  = !has_two;
    second_rec             = rec_tail;
    second_rec.last_result = 1'b1;
  end

  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    if (pend_valid_q && out_free) begin
      out_valid_d  = 1'b1;
      out_d        = pend_q;
      pend_valid_d = 1'b0;
    end else if (q_pop_o) begin
      out_valid_d  = has_any;
      out_d        = first_rec;
      pend_valid_d = has_two;
      pend_d       = second_rec;
    end else if (out_free) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= btlv_pkg::STATE_CLEAR;
      max_tokens_q <= btlv_pkg::MAX_TOKENS_RESET;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
      if (cfg_valid_i) begin
        max_tokens_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    pend_q <= pend_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_IMPL(a_pend_behind_out, pend_valid_q, out_valid_q, "second result without first")
  `ASSERT_IMPL(a_no_pop_with_pend, q_pop_o, !pend_valid_q, "byte taken with result pending")
  `ASSERT_IMPL(a_value_owed, state_q.phase == btlv_pkg::PH_VALUE, state_q.val_left != '0,
               "value phase with nothing owed")
  `ASSERT_NEXT(a_final_clears, q_pop_o && q_data_i.fin, state_q.offset == '0,
               "state not cleared after final byte")

endmodule

`default_nettype wire

// File: rtl/ber_tlv_stream_parser.sv
// ----------------------------------------------------------------------------
// ber_tlv_stream_parser
// BER tag-length-value parser: one buffer byte in, token/done/error out.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake        | payload
//  in       | in        | in_valid/stall   | data_byte, final_byte
//  out      | out       | out_valid/stall  | kind, tag, length, offset, ...
//  cfg      | in        | cfg_valid/ready  | max_tokens (16 bit)
//
//  One byte per cycle is taken while the queue has room; a byte that yields
//  a token and a done or error result holds the parser while the second
//  result leaves from its holding slot. A byte passes through the queue and
//  then the output register. The four-entry queue separates input from the
//  parser, so input stalls only when it fills. Reset is asynchronous;
//  max_tokens resets to 65535.
`timescale 1ns / 1ps
`default_nettype none

module ber_tlv_stream_parser (
  input  var logic               clk_i,
  input  var logic               rst_ni,
  input  var logic               in_valid_i,
  output logic                   in_stall_o,
  input  var btlv_pkg::btlv_in_t in_data_i,
  output logic                   out_valid_o,
  input  var logic               out_stall_i,
  output btlv_pkg::btlv_out_t    out_data_o,
  input  var logic               cfg_valid_i,
  output logic                   cfg_ready_o,
  input  var logic [15:0]        cfg_data_i
);

  btlv_pkg::btlv_cls_t cls, q_data;
  logic                full, q_avail, q_pop;

  assign in_stall_o  = full;
  assign cfg_ready_o = 1'b1;

  btlv_front u_front (
    .in_data_i (in_data_i),
    .cls_o     (cls)
  );

  btlv_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i && !full),
    .push_data_i (cls),
    .full_o      (full),
    .not_empty_o (q_avail),
    .pop_i       (q_pop),
    .pop_data_o  (q_data)
  );

  btlv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_avail_i   (q_avail),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
